[rtl/core/kmd_pkg.sv]
package kmd_pkg;

   // default matrix size
   localparam int unsigned ROWS_DEF = 8;
   localparam int unsigned COLS_DEF = 8;

   // field widths
   localparam int unsigned HIST_W    = 8;
   localparam int unsigned COUNT_W   = 7;
   localparam int unsigned KEY_IDX_W = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_THR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_KEY_A  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_KEY_B  = 3'd4;

   // register reset values
   localparam logic [HIST_W-1:0]    PRESS_THR_RST   = 8'd192;
   localparam logic [HIST_W-1:0]    RELEASE_THR_RST = 8'd63;
   localparam logic                 LOCK_MODE_RST   = 1'b0;
   localparam logic [KEY_IDX_W-1:0] WAKE_KEY_A_RST  = 6'd20;
   localparam logic [KEY_IDX_W-1:0] WAKE_KEY_B_RST  = 6'd49;

   // input word
   typedef struct packed {
      logic       raw_pressed;
      logic [2:0] key_row;
      logic [2:0] key_col;
      logic       last_key;
   } req_type;

   // result word
   typedef struct packed {
      logic               key_down;
      logic               history_active;
      logic               scan_done;
      logic [COUNT_W-1:0] active_count;
      logic [COUNT_W-1:0] debounced_total;
      logic               wake;
   } rsp_type;

   // per-key update event towards the scan accumulator
   typedef struct packed {
      logic fire;
      logic active;
      logic db_set;
      logic db_clr;
      logic is_a;
      logic is_b;
      logic raw;
      logic last;
   } kmd_evt_type;

   // end-of-scan summary
   typedef struct packed {
      logic [COUNT_W-1:0] active_count;
      logic [COUNT_W-1:0] debounced_total;
      logic               wake;
   } kmd_sum_type;

endpackage

[rtl/core/kmd_ram.sv]
module kmd_ram #(
   parameter int unsigned WIDTH = 9,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port, old data on collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/kmd_scan_acc.sv]
module kmd_scan_acc #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 lock_mode,
   input  kmd_pkg::kmd_evt_type evt,
   output kmd_pkg::kmd_sum_type sum
);
   import kmd_pkg::*;

   localparam int unsigned PT_W = $clog2(DEPTH + 1);

   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [PT_W-1:0]    pt_ff, pt_in;
   logic               a_ff, a_in;
   logic               b_ff, b_in;
   logic               other_ff, other_in;
   logic               raw_ff, raw_in;

   // scan count saturates, it only ever reports up to the cap
   always_comb begin
      cnt_in = cnt_ff;
      if (evt.active && cnt_ff != COUNT_MAX) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end
   end

   // running total of debounced keys
   always_comb begin
      pt_in = pt_ff;
      if (evt.db_set) begin
         pt_in = pt_ff + PT_W'(1);
      end else if (evt.db_clr) begin
         pt_in = pt_ff - PT_W'(1);
      end
   end

   // wake key tracking
   assign a_in     = a_ff | (evt.active & evt.is_a);
   assign b_in     = b_ff | (evt.active & evt.is_b);
   assign other_in = other_ff | (evt.active & ~evt.is_a & ~evt.is_b);
   assign raw_in   = raw_ff | evt.raw;

   // summary including the current key
   always_comb begin
      sum.active_count = cnt_in;
      if (32'(pt_in) > 32'(COUNT_MAX)) begin
         sum.debounced_total = COUNT_MAX;
      end else begin
         sum.debounced_total = COUNT_W'(pt_in);
      end
      sum.wake = lock_mode ? (a_in & b_in & ~other_in) : raw_in;
   end

   // per-scan state clears after the last key
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         pt_ff    <= '0;
         a_ff     <= 1'b0;
         b_ff     <= 1'b0;
         other_ff <= 1'b0;
         raw_ff   <= 1'b0;
      end else if (evt.fire) begin
         pt_ff <= pt_in;
         if (evt.last) begin
            cnt_ff   <= '0;
            a_ff     <= 1'b0;
            b_ff     <= 1'b0;
            other_ff <= 1'b0;
            raw_ff   <= 1'b0;
         end else begin
            cnt_ff   <= cnt_in;
            a_ff     <= a_in;
            b_ff     <= b_in;
            other_ff <= other_in;
            raw_ff   <= raw_in;
         end
      end
   end

endmodule

[rtl/core/key_matrix_debounce_scanner.sv]
// channel | direction | handshake             | word
// req     | in        | req_valid / req_stall | kmd_pkg::req_type
// rsp     | out       | rsp_valid / rsp_stall | kmd_pkg::rsp_type
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// one key per cycle sustained while rsp_stall is low; rsp_valid rises once its key has passed
// the update stage (memory read on the taking edge, then update into the output register)
// after reset a clearing pass zeroes all ROWS*COLS key memory entries (64 by default),
// with req_stall held high; csr writes are taken throughout
// rsp_stall reaches req_stall in the same cycle once update stage and output are full
module key_matrix_debounce_scanner #(
   parameter int unsigned ROWS = kmd_pkg::ROWS_DEF,
   parameter int unsigned COLS = kmd_pkg::COLS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  kmd_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output kmd_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kmd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kmd_pkg::CSR_DAT_W-1:0]    csr_data
);
   import kmd_pkg::*;

   localparam int unsigned DEPTH = ROWS * COLS;
   localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = (IW > KEY_IDX_W) ? IW : KEY_IDX_W;
   localparam int unsigned EW    = HIST_W + 1;

   // configuration
   logic [HIST_W-1:0]    press_thr_ff;
   logic [HIST_W-1:0]    release_thr_ff;
   logic                 lock_mode_ff;
   logic [KEY_IDX_W-1:0] wake_a_ff;
   logic [KEY_IDX_W-1:0] wake_b_ff;

   // clearing pass
   logic          clearing_ff;
   logic [IW-1:0] clr_addr_ff;

   // update stage
   logic          s1_valid_ff;
   logic [IW-1:0] s1_idx_ff;
   logic          s1_in_range_ff;
   logic          s1_raw_ff;
   logic          s1_last_ff;

   // last write, for forwarding
   logic          lw_valid_ff;
   logic [IW-1:0] lw_addr_ff;
   logic [EW-1:0] lw_data_ff;

   // output register
   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic          req_take;
   logic          s1_adv;
   logic          commit;
   logic [IW-1:0] req_idx;
   logic          req_in_range;
   logic [EW-1:0] rd_data;
   logic [EW-1:0] old_entry;
   logic [HIST_W-1:0] hist_new;
   logic          db_old, db_new, ge_press, le_release;
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   kmd_evt_type   evt;
   kmd_sum_type   sum;
   rsp_type       rsp_next;

   // handshakes
   assign s1_adv    = ~out_valid_ff | ~rsp_stall;
   assign req_stall = clearing_ff | (s1_valid_ff & ~s1_adv);
   assign req_take  = req_valid & ~req_stall;
   assign commit    = s1_valid_ff & s1_adv;
   assign csr_ready = 1'b1;

   // key index of the incoming sample
   assign req_in_range = (32'(req_data.key_row) < ROWS) && (32'(req_data.key_col) < COLS);
   assign req_idx      = IW'(32'(req_data.key_row) * COLS + 32'(req_data.key_col));

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         press_thr_ff   <= PRESS_THR_RST;
         release_thr_ff <= RELEASE_THR_RST;
         lock_mode_ff   <= LOCK_MODE_RST;
         wake_a_ff      <= WAKE_KEY_A_RST;
         wake_b_ff      <= WAKE_KEY_B_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRESS_THR:   press_thr_ff   <= csr_data;
            CSR_RELEASE_THR: release_thr_ff <= csr_data;
            CSR_LOCK_MODE:   lock_mode_ff   <= csr_data[0];
            CSR_WAKE_KEY_A:  wake_a_ff      <= csr_data[KEY_IDX_W-1:0];
            CSR_WAKE_KEY_B:  wake_b_ff      <= csr_data[KEY_IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // key memory: debounced bit over history
   kmd_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_take),
      .raddr (req_idx),
      .rdata (rd_data)
   );

   // forward the previous write over a stale read
   assign old_entry = (lw_valid_ff && lw_addr_ff == s1_idx_ff) ? lw_data_ff : rd_data;

   // history shift and threshold compare
   always_comb begin
      hist_new   = {s1_raw_ff, old_entry[HIST_W-1:1]};
      db_old     = old_entry[HIST_W];
      ge_press   = hist_new >= press_thr_ff;
      le_release = hist_new <= release_thr_ff;
      if (ge_press) begin
         db_new = 1'b1;
      end else if (le_release) begin
         db_new = 1'b0;
      end else begin
         db_new = db_old;
      end
   end

   // write back, or zero fill during the clearing pass
   assign ram_we    = clearing_ff | (commit & s1_in_range_ff);
   assign ram_waddr = clearing_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wdata = clearing_ff ? '0 : {db_new, hist_new};

   // event for the scan accumulator
   always_comb begin
      evt.fire     = commit;
      evt.active   = commit & s1_in_range_ff & (hist_new != '0);
      evt.db_set   = commit & s1_in_range_ff & ge_press & ~db_old;
      evt.db_clr   = commit & s1_in_range_ff & ~ge_press & le_release & db_old;
      evt.is_a     = CW'(s1_idx_ff) == CW'(wake_a_ff);
      evt.is_b     = CW'(s1_idx_ff) == CW'(wake_b_ff);
      evt.raw      = commit & s1_raw_ff;
      evt.last     = s1_last_ff;
   end

   kmd_scan_acc #(
      .DEPTH (DEPTH)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .lock_mode (lock_mode_ff),
      .evt       (evt),
      .sum       (sum)
   );

   // result word
   always_comb begin
      rsp_next.key_down        = s1_in_range_ff & db_new;
      rsp_next.history_active  = s1_in_range_ff & (hist_new != '0);
      rsp_next.scan_done       = s1_last_ff;
      rsp_next.active_count    = s1_last_ff ? sum.active_count : '0;
      rsp_next.debounced_total = s1_last_ff ? sum.debounced_total : '0;
      rsp_next.wake            = s1_last_ff & sum.wake;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + IW'(1);
            if (clr_addr_ff == IW'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (commit) begin
            s1_valid_ff <= 1'b0;
         end
         if (commit && s1_in_range_ff) begin
            lw_valid_ff <= 1'b1;
         end
         if (commit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_idx_ff      <= req_idx;
         s1_in_range_ff <= req_in_range;
         s1_raw_ff      <= req_data.raw_pressed;
         s1_last_ff     <= req_data.last_key;
      end
      if (commit && s1_in_range_ff) begin
         lw_addr_ff <= s1_idx_ff;
         lw_data_ff <= {db_new, hist_new};
      end
      if (commit) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/core/kmd_checker.sv]
module kmd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kmd_pkg::rsp_type rsp_data
);
   import kmd_pkg::*;

   // a stalled result word holds
   rsp_hold_a : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // scan summary fields stay zero away from the end of a scan
   summary_zero_a : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.scan_done |->
         rsp_data.active_count == '0 && rsp_data.debounced_total == '0 && !rsp_data.wake)
      else $error("summary fields set without scan end");

   // an active last key is counted in its own scan
   count_self_a : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scan_done && rsp_data.history_active |->
         rsp_data.active_count != '0)
      else $error("active last key missing from count");

   // req_stall is high following reset, at the start of the clearing pass
   clear_stall_a : assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken during clearing pass");

endmodule

bind key_matrix_debounce_scanner kmd_checker u_checker (.*);
